[hw/rtl/dlr_pkg.sv]
package dlr_pkg;

  localparam int COORD_W   = 24;
  localparam int DIFF_W    = 25;
  localparam int SLOPE_W   = 18;
  localparam int QUO_W     = 17;
  localparam int PIX_W     = 16;
  localparam int COLOR_W   = 32;
  localparam int CFG_W     = 13;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic load_start;
    logic diff;
    logic order;
    logic clip;
    logic drop_line;
    logic div_step;
    logic finish;
    logic step_mul;
    logic minor;
    logic emit;
  } dlr_cmd_t;

  typedef struct packed {
    logic active;
    logic dmaj_zero;
    logic out_free;
  } dlr_status_t;

endpackage

[hw/rtl/dlr_regs.sv]
module dlr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dlr_pkg::ADDR_W-1:0]  paddr,
  input  logic [dlr_pkg::DATA_W-1:0]  pwdata,
  output logic [dlr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [dlr_pkg::CFG_W-1:0]   image_width,
  output logic [dlr_pkg::CFG_W-1:0]   image_height
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= dlr_pkg::WIDTH_RESET;
      image_height <= dlr_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        dlr_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[dlr_pkg::CFG_W-1:0];
        dlr_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[dlr_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dlr_pkg::REG_IMAGE_WIDTH:  prdata = dlr_pkg::DATA_W'(image_width);
      dlr_pkg::REG_IMAGE_HEIGHT: prdata = dlr_pkg::DATA_W'(image_height);
      default:                   prdata = '0;
    endcase
  end

endmodule

[hw/rtl/dlr_ctrl.sv]
module dlr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 opcode,
  output logic                 in_ready,
  input  dlr_pkg::dlr_status_t status,
  output dlr_pkg::dlr_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIFF  = 8'b0000_0010,
    S_ORDER = 8'b0000_0100,
    S_CLIP  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_MINOR = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [dlr_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic [dlr_pkg::DIV_CNT_W-1:0]   div_cnt_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == dlr_pkg::OP_START) begin
            cmd.load_start = 1'b1;
            state_next     = S_DIFF;
          end else if (status.active) begin
            cmd.step_mul = 1'b1;
            state_next   = S_MINOR;
          end
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_ORDER;
      end
      S_ORDER: begin
        cmd.order  = 1'b1;
        state_next = S_CLIP;
      end
      S_CLIP: begin
        cmd.clip     = 1'b1;
        div_cnt_next = '0;
        if (status.dmaj_zero) begin
          cmd.drop_line = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + dlr_pkg::DIV_CNT_W'(1);
        if (div_cnt == dlr_pkg::DIV_CNT_W'(dlr_pkg::DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_MINOR: begin
        cmd.minor  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the pixel
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/dlr_datapath.sv]
module dlr_datapath #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dlr_pkg::dlr_cmd_t                   cmd,
  output dlr_pkg::dlr_status_t                status,
  input  logic signed [dlr_pkg::COORD_W-1:0]  start_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]  start_y,
  input  logic signed [dlr_pkg::COORD_W-1:0]  end_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]  end_y,
  input  logic        [dlr_pkg::COLOR_W-1:0]  line_color,
  input  logic        [dlr_pkg::CFG_W-1:0]    image_width,
  input  logic        [dlr_pkg::CFG_W-1:0]    image_height,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [dlr_pkg::PIX_W-1:0]    pixel_x,
  output logic signed [dlr_pkg::PIX_W-1:0]    pixel_y,
  output logic        [dlr_pkg::COLOR_W-1:0]  pixel_color,
  output logic                                drawn,
  output logic                                last
);

  localparam int CW     = dlr_pkg::COORD_W;
  localparam int DW     = dlr_pkg::DIFF_W;
  localparam int SW     = dlr_pkg::SLOPE_W;
  localparam int QW     = dlr_pkg::QUO_W;
  localparam int PW     = dlr_pkg::PIX_W;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int SC_W   = DIM_W + FRAC_BITS;
  localparam int HI_W   = ((SC_W > CW) ? SC_W : CW) + 1;
  localparam int MIN_W  = DW + 1;
  localparam int PROD_W = MIN_W + SW;

  localparam logic [DW-1:0]           ONE       = DW'(1) << FRAC_BITS;
  localparam logic [MIN_W-1:0]        FRAC_MASK = MIN_W'(ONE) - MIN_W'(1);
  localparam logic signed [MIN_W-1:0] SAT_HI    = MIN_W'(32767);
  localparam logic signed [MIN_W-1:0] SAT_LO    = MIN_W'(-32768);
  localparam logic signed [CW-1:0]    POS_HI    = CW'(32767);

  // latched endpoints and line setup
  logic signed [CW-1:0]     sx, sy, ex, ey;
  logic signed [DW-1:0]     dx, dy;
  logic                     y_is_major;
  logic        [DW-1:0]     dmaj, dmin_mag;
  logic                     slope_neg;
  logic signed [CW-1:0]     amaj, amin, bmaj;
  logic        [DIM_W-1:0]  dim_sel;
  logic        [dlr_pkg::COLOR_W-1:0] held_color;

  // walk state
  logic signed [CW-1:0]     origin_minor;
  logic        [DW-1:0]     off;
  logic signed [CW-1:0]     major_pos;
  logic signed [CW-1:0]     major_stop;
  logic signed [SW-1:0]     slope;
  logic                     active;

  // divider
  logic        [DW-1:0]     rem;
  logic        [QW-1:0]     quo;

  // step pipeline
  logic signed [PROD_W-1:0] prod;
  logic signed [MIN_W-1:0]  minor;
  logic signed [PW-1:0]     pmaj;
  logic signed [DW-1:0]     pos_next;
  logic                     last_step;

  // setup logic
  logic [DIM_W-1:0]         dim_w_c, dim_h_c;
  logic [DW-1:0]            adx, ady;
  logic                     ymaj, swap, dmin_sign;
  logic signed [CW-1:0]     maj_s, maj_e, min_s, min_e;
  logic signed [DW-1:0]     amaj_e;
  logic signed [HI_W-1:0]   bmaj_e, dim_sc;
  logic signed [CW-1:0]     clip_hi;

  // divide step
  logic [DW:0]              trial;
  logic                     q_bit;
  logic [DW-1:0]            rem_sub;

  // pixel logic
  logic signed [PROD_W-1:0] prod_sh;
  logic                     prod_rnd;
  logic signed [MIN_W-1:0]  minor_sum;
  logic signed [CW-1:0]     pos_sh;
  logic signed [DW-1:0]     pos_add;
  logic signed [MIN_W-1:0]  min_sh, pmin_raw;
  logic                     min_rnd;
  logic signed [PW-1:0]     pmin, px, py;
  logic                     px_in, py_in;

  // clamp oversize registers to the largest supported image
  assign dim_w_c = (32'(image_width) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(image_width);
  assign dim_h_c = (32'(image_height) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(image_height);

  assign adx       = dx[DW-1] ? -dx : dx;
  assign ady       = dy[DW-1] ? -dy : dy;
  assign ymaj      = !(ady < adx);
  assign swap      = ymaj ? dy[DW-1] : dx[DW-1];
  assign dmin_sign = ymaj ? dx[DW-1] : dy[DW-1];
  assign maj_s     = ymaj ? sy : sx;
  assign maj_e     = ymaj ? ey : ex;
  assign min_s     = ymaj ? sx : sy;
  assign min_e     = ymaj ? ex : ey;

  assign amaj_e  = DW'(amaj);
  assign bmaj_e  = HI_W'(bmaj);
  assign dim_sc  = $signed(HI_W'(dim_sel) << FRAC_BITS);
  assign clip_hi = (bmaj_e < dim_sc) ? bmaj : dim_sc[CW-1:0];

  // restoring divide, one quotient bit per cycle
  assign trial   = {1'b0, rem} - {1'b0, dmaj};
  assign q_bit   = !trial[DW];
  assign rem_sub = q_bit ? trial[DW-1:0] : rem;

  // minor = origin + product / 2^16, truncated toward zero
  assign prod_sh   = prod >>> 16;
  assign prod_rnd  = prod[PROD_W-1] && (prod[15:0] != 16'd0);
  assign minor_sum = MIN_W'(origin_minor) + prod_sh[MIN_W-1:0] + MIN_W'(prod_rnd);
  assign pos_sh    = major_pos >>> FRAC_BITS;
  assign pos_add   = DW'(major_pos) + $signed(ONE);

  assign min_sh   = minor >>> FRAC_BITS;
  assign min_rnd  = minor[MIN_W-1] && ((minor & FRAC_MASK) != '0);
  assign pmin_raw = min_sh + MIN_W'(min_rnd);

  always_comb begin
    priority if (pmin_raw > SAT_HI) begin
      pmin = PW'(SAT_HI);
    end else if (pmin_raw < SAT_LO) begin
      pmin = PW'(SAT_LO);
    end else begin
      pmin = pmin_raw[PW-1:0];
    end
  end

  assign px    = y_is_major ? pmin : pmaj;
  assign py    = y_is_major ? pmaj : pmin;
  assign px_in = !px[PW-1] && (PW'(image_width) > $unsigned(px));
  assign py_in = !py[PW-1] && (PW'(image_height) > $unsigned(py));

  assign status.active    = active;
  assign status.dmaj_zero = (dmaj == '0);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.drop_line) begin
        active <= 1'b0;
      end else if (cmd.finish) begin
        active <= (major_pos < major_stop);
      end else if (cmd.emit) begin
        active <= !last_step;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      sx         <= start_x;
      sy         <= start_y;
      ex         <= end_x;
      ey         <= end_y;
      held_color <= line_color;
    end
    if (cmd.diff) begin
      dx <= DW'(ex) - DW'(sx);
      dy <= DW'(ey) - DW'(sy);
    end
    if (cmd.order) begin
      y_is_major <= ymaj;
      amaj       <= swap ? maj_e : maj_s;
      amin       <= swap ? min_e : min_s;
      bmaj       <= swap ? maj_s : maj_e;
      dmaj       <= ymaj ? ady : adx;
      dmin_mag   <= ymaj ? adx : ady;
      slope_neg  <= dmin_sign ^ swap;
      dim_sel    <= ymaj ? dim_h_c : dim_w_c;
    end
    if (cmd.clip) begin
      origin_minor <= amin;
      off          <= amaj[CW-1] ? -amaj_e : '0;
      major_pos    <= amaj[CW-1] ? '0 : amaj;
      major_stop   <= clip_hi;
      rem          <= dmin_mag;
      quo          <= '0;
    end
    if (cmd.div_step) begin
      rem <= {rem_sub[DW-2:0], 1'b0};
      quo <= {quo[QW-2:0], q_bit};
    end
    if (cmd.finish) begin
      slope <= slope_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
    if (cmd.step_mul) begin
      prod <= $signed({1'b0, off}) * slope;
    end
    if (cmd.minor) begin
      minor     <= minor_sum;
      pmaj      <= (pos_sh > POS_HI) ? PW'(POS_HI) : pos_sh[PW-1:0];
      pos_next  <= pos_add;
      last_step <= !(pos_add < DW'(major_stop));
    end
    if (cmd.emit) begin
      pixel_x     <= px;
      pixel_y     <= py;
      pixel_color <= held_color;
      drawn       <= px_in && py_in;
      last        <= last_step;
      major_pos   <= pos_next[CW-1:0];
      off         <= off + ONE;
    end
  end

endmodule

[hw/rtl/dda_line_rasterizer.sv]
// DDA line rasterizer.
// Input channel (in_valid/in_ready): opcode 0 starts a line between two
// signed fixed-point endpoints and latches its color; opcode 1 asks for the
// next pixel of the active line. Output channel (out_valid/out_ready): one
// pixel transaction per step with coordinates, color, drawn and last flags.
// Image size comes from the APB registers image_width (0x0) and
// image_height (0x4); write them only while the block is idle.
// A line start keeps in_ready low after acceptance while the line is set
// up (difference, ordering and clipping states), while the restoring
// divider forms the slope one quotient bit per cycle, and through the
// finish state. A degenerate line is dropped in the clipping state. A step
// runs multiply, minor sum and pixel stages in order, and in_ready stays
// low until the pixel is taken into the output register. A step with no
// active line is taken and gives nothing.
// Reset clears the active line and the output register and loads the image
// size registers with 640 x 480. When the receiver stalls, the pending pixel
// holds in the output register; the block still takes one more item and
// parks its pixel until the output register frees.
module dda_line_rasterizer #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [dlr_pkg::ADDR_W-1:0]   paddr,
  input  logic        [dlr_pkg::DATA_W-1:0]   pwdata,
  output logic        [dlr_pkg::DATA_W-1:0]   prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic signed [dlr_pkg::COORD_W-1:0]  start_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]  start_y,
  input  logic signed [dlr_pkg::COORD_W-1:0]  end_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]  end_y,
  input  logic        [dlr_pkg::COLOR_W-1:0]  line_color,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dlr_pkg::PIX_W-1:0]    pixel_x,
  output logic signed [dlr_pkg::PIX_W-1:0]    pixel_y,
  output logic        [dlr_pkg::COLOR_W-1:0]  pixel_color,
  output logic                                drawn,
  output logic                                last
);

  logic [dlr_pkg::CFG_W-1:0] image_width;
  logic [dlr_pkg::CFG_W-1:0] image_height;
  dlr_pkg::dlr_cmd_t         cmd;
  dlr_pkg::dlr_status_t      status;
  logic                      in_take;

  assign in_take = in_valid && in_ready;

  // image size registers
  dlr_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // sequencer: line setup, divide, and the step stages
  dlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // endpoint ordering, clipping, slope divider, pixel arithmetic, output register
  dlr_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .line_color   (line_color),
    .image_width  (image_width),
    .image_height (image_height),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color),
    .drawn        (drawn),
    .last         (last)
  );

  // a line start blocks the input while the line is set up
  a_start_blocks : assert property (@(posedge clk) disable iff (rst)
    in_take && (opcode == dlr_pkg::OP_START) |=> !in_ready)
    else $error("input taken during line setup");

  // a step on an active line blocks the input while the pixel is formed
  a_step_blocks : assert property (@(posedge clk) disable iff (rst)
    in_take && (opcode == dlr_pkg::OP_STEP) && status.active |=> !in_ready)
    else $error("input taken during pixel step");

  // a new pixel appears only through the emit command
  a_out_from_emit : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid without emit");

  // a drawn pixel never has a negative coordinate
  a_drawn_inside : assert property (@(posedge clk) disable iff (rst)
    out_valid && drawn |-> !pixel_x[dlr_pkg::PIX_W-1] && !pixel_y[dlr_pkg::PIX_W-1])
    else $error("drawn pixel outside image");

endmodule
